// File: rtl/rsc_pkg.sv
// Shared types and constants for the RGB 3x3 sharpen core.
// No dependencies; imported by every module of the block.
`default_nettype none

package rsc_pkg;

  localparam int PIX_W      = 24;
  localparam int ROW_W      = 12;
  localparam int FW_W       = 12;
  localparam int FH_W       = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int MAX_HEIGHT = 4096;
  localparam int N_CAND     = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;

  // Position of the pixel in stage A relative to the frame edges
  typedef struct packed {
    logic r_ge1;
    logic r_ge2;
    logic r_last;
    logic c_ge1;
    logic c_ge2;
    logic c_last;
  } rsc_flags_t;

  // Up to four results released by one pixel, in output order
  typedef struct packed {
    logic [N_CAND-1:0] mask;
    pix_t [N_CAND-1:0] pix;
  } rsc_cand_t;

endpackage

`default_nettype wire

// File: rtl/rsc_line_mem.sv
// Line memory: one entry per column holding the two previous rows' pixels.
// Registered read with write-to-read forwarding. Uses rsc_pkg.
`default_nettype none

module rsc_line_mem #(
  parameter int DEPTH = 2048
) (
  input  wire                          clk,
  input  wire                          rd_en,
  input  wire  [$clog2(DEPTH)-1:0]     rd_addr,
  input  wire                          wr_en,
  input  wire  [$clog2(DEPTH)-1:0]     wr_addr,
  input  wire  [2*rsc_pkg::PIX_W-1:0]  wr_data,
  output logic [2*rsc_pkg::PIX_W-1:0]  rd_data
);
  import rsc_pkg::*;

  logic [2*PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // hold the read word until the next read; bypass a write to the same entry
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/rsc_scan.sv
// Raster scan stage: frame size registers, row/column counters and stage A.
// Issues the line memory read address. Uses rsc_pkg.
`default_nettype none

module rsc_scan #(
  parameter int MAX_WIDTH = 2048
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 cfg_we,
  input  wire  [rsc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [rsc_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire                                 in_valid,
  input  wire  [rsc_pkg::PIX_W-1:0]           in_pix,
  input  wire                                 advance,
  output logic                                in_stall,
  output logic                                accept,
  output logic [$clog2(MAX_WIDTH)-1:0]        rd_col,
  output logic                                a_valid,
  output rsc_pkg::pix_t                       a_pix,
  output logic [$clog2(MAX_WIDTH)-1:0]        a_col,
  output rsc_pkg::rsc_flags_t                 a_flags
);
  import rsc_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  logic [FW_W-1:0]  frame_width;
  logic [FH_W-1:0]  frame_height;
  logic [ROW_W-1:0] row_count, row_count_next;
  logic [CW-1:0]    column_count, column_count_next;
  logic [CW-1:0]    w_last, col;
  logic [ROW_W-1:0] h_last, row;
  rsc_flags_t       flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FW_W'(640);
      frame_height <= FH_W'(480);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width  <= cfg_data[FW_W-1:0];
        CFG_FRAME_HEIGHT: frame_height <= cfg_data[FH_W-1:0];
        default:          ;
      endcase
    end
  end

  // clamp the frame size and the counters to it, then derive the edge flags and next counts
  always_comb begin
    if ({2'b00, frame_width} > 14'(MAX_WIDTH)) begin
      w_last = CW'(MAX_WIDTH - 1);
    end else if (frame_width < FW_W'(2)) begin
      w_last = CW'(1);
    end else begin
      w_last = CW'(frame_width - FW_W'(1));
    end
    if (frame_height > FH_W'(MAX_HEIGHT)) begin
      h_last = ROW_W'(MAX_HEIGHT - 1);
    end else if (frame_height < FH_W'(2)) begin
      h_last = ROW_W'(1);
    end else begin
      h_last = ROW_W'(frame_height - FH_W'(1));
    end
    col = (column_count > w_last) ? w_last : column_count;
    row = (row_count > h_last) ? h_last : row_count;

    flags.r_ge1  = (row != '0);
    flags.r_ge2  = (row >= ROW_W'(2));
    flags.r_last = (row == h_last);
    flags.c_ge1  = (col != '0);
    flags.c_ge2  = (col >= CW'(2));
    flags.c_last = (col == w_last);

    if (flags.c_last) begin
      column_count_next = '0;
      row_count_next    = flags.r_last ? '0 : row + ROW_W'(1);
    end else begin
      column_count_next = col + CW'(1);
      row_count_next    = row;
    end
  end

  assign in_stall = a_valid && !advance;
  assign accept   = in_valid && !in_stall;
  assign rd_col   = col;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= '0;
      column_count <= '0;
      a_valid      <= 1'b0;
    end else if (accept) begin
      row_count    <= row_count_next;
      column_count <= column_count_next;
      a_valid      <= 1'b1;
    end else if (advance) begin
      a_valid      <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_pix   <= in_pix;
      a_col   <= col;
      a_flags <= flags;
    end
  end

endmodule

`default_nettype wire

// File: rtl/rsc_kernel.sv
// Window registers and sharpen arithmetic; builds the result candidates.
// Fed by the line memory read word and stage A. Uses rsc_pkg.
`default_nettype none

module rsc_kernel (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  load,
  input  rsc_pkg::pix_t        upper,
  input  rsc_pkg::pix_t        middle,
  input  rsc_pkg::pix_t        px,
  input  rsc_pkg::rsc_flags_t  flags,
  output rsc_pkg::rsc_cand_t   cand
);
  import rsc_pkg::*;

  // window columns kept from the previous pixel
  pix_t top_prev;   // upper row, previous column
  pix_t mid_prev2;  // middle row, two columns back
  pix_t mid_prev;   // middle row, previous column
  pix_t bot_prev;   // current row, previous column
  pix_t sharp;

  function automatic logic [7:0] sharp_chan(input logic [7:0] c, input logic [7:0] u,
                                            input logic [7:0] d, input logic [7:0] l,
                                            input logic [7:0] r);
    logic [11:0] v;
    logic [11:0] mag;
    v   = {2'b00, c, 2'b00} + {4'b0000, c} - {4'b0000, u} - {4'b0000, d}
        - {4'b0000, l} - {4'b0000, r};
    mag = v[11] ? (~v + 12'd1) : v;
    return mag[7:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      top_prev  <= '0;
      mid_prev2 <= '0;
      mid_prev  <= '0;
      bot_prev  <= '0;
    end else if (load) begin
      top_prev  <= upper;
      mid_prev2 <= mid_prev;
      mid_prev  <= middle;
      bot_prev  <= px;
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sharp[ch*8 +: 8] = sharp_chan(mid_prev[ch*8 +: 8], top_prev[ch*8 +: 8],
                                    bot_prev[ch*8 +: 8], mid_prev2[ch*8 +: 8],
                                    middle[ch*8 +: 8]);
    end
    cand.mask[0] = flags.r_ge1 && flags.c_ge1;
    cand.pix[0]  = (flags.r_ge2 && flags.c_ge2) ? sharp : mid_prev;
    cand.mask[1] = flags.r_ge1 && flags.c_last;
    cand.pix[1]  = middle;
    cand.mask[2] = flags.r_last && flags.c_ge1;
    cand.pix[2]  = bot_prev;
    cand.mask[3] = flags.r_last && flags.c_last;
    cand.pix[3]  = px;
  end

endmodule

`default_nettype wire

// File: rtl/rsc_result_q.sv
// Result set register: holds the results of one pixel and sends one per cycle unless stalled.
// Candidates come from rsc_kernel. Uses rsc_pkg.
`default_nettype none

module rsc_result_q (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 load,
  input  rsc_pkg::rsc_cand_t  cand,
  input  wire                 out_stall,
  output logic                free,
  output logic                out_valid,
  output rsc_pkg::pix_t       out_pix,
  output logic                last_of_run,
  output logic                end_of_frame
);
  import rsc_pkg::*;

  logic [N_CAND-1:0] mask;
  pix_t [N_CAND-1:0] pix;
  logic [N_CAND-1:0] sel, remaining;
  logic              take;

  always_comb begin
    sel       = mask & (~mask + N_CAND'(1));
    remaining = mask & ~sel;
    out_pix   = '0;
    for (int i = 0; i < N_CAND; i++) begin
      if (sel[i]) begin
        out_pix = out_pix | pix[i];
      end
    end
  end

  assign out_valid    = (mask != '0);
  assign last_of_run  = (remaining == '0);
  assign end_of_frame = sel[N_CAND-1];
  assign take         = out_valid && !out_stall;
  assign free         = !out_valid || (take && last_of_run);

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (load) begin
      mask <= cand.mask;
    end else if (take) begin
      mask <= remaining;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pix <= cand.pix;
    end
  end

endmodule

`default_nettype wire

// File: rtl/rgb_sharpen_convolution_3x3_core.sv
// RGB 3x3 sharpen convolution core: top level.
// Instantiates rsc_scan, rsc_line_mem, rsc_kernel and rsc_result_q; uses rsc_pkg.
//
// Pixels enter in raster order on the input channel (in_valid/in_stall,
// red_in/green_in/blue_in); a transaction completes on a clock edge with
// valid high and stall low. Filtered pixels leave in raster order, the last
// two rows interleaved by column; last_of_run marks the final result of one
// input, end_of_frame the bottom-right pixel; border pixels pass unchanged.
// Set the frame size through cfg_we/cfg_index/cfg_data only while idle.
// Path: a transaction registers its pixel in stage A, which reads the line
// memory; the result set then registers the results that it releases and
// drives the port.
// Throughput: the result set sends one result per cycle unless out_stall
// holds it; stage A waits until a pixel's last result is taken. One pixel
// per cycle within a row; two results for the last pixel of a middle row
// and each last-row pixel after the first, four for the bottom-right one.
// Reset clears counters, window and valids and loads a 640x480 frame; the
// line memory is not cleared, as no result depends on an entry read before
// it is written. When the receiver stalls, results hold, stage A fills and
// in_stall rises; nothing is dropped.
`default_nettype none

module rgb_sharpen_convolution_3x3_core #(
  parameter int MAX_WIDTH = 2048
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             cfg_we,
  input  wire  [rsc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [rsc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire  [7:0]                      red_in,
  input  wire  [7:0]                      green_in,
  input  wire  [7:0]                      blue_in,
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic [7:0]                      red_out,
  output logic [7:0]                      green_out,
  output logic [7:0]                      blue_out,
  output logic                            last_of_run,
  output logic                            end_of_frame
);
  import rsc_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  logic               accept;
  logic               advance;     // stage A hands its pixel to the window
  logic               res_free;
  logic [CW-1:0]      rd_col;
  logic               a_valid;
  pix_t               a_pix;
  logic [CW-1:0]      a_col;
  rsc_flags_t         a_flags;
  logic [2*PIX_W-1:0] line_word;   // {upper row, middle row} of this column
  rsc_cand_t          cand;
  pix_t               out_pix;

  // advance stage A whenever the result set empties this cycle
  assign advance = a_valid && res_free;

  rsc_scan #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_pix    ({blue_in, green_in, red_in}),
    .advance   (advance),
    .in_stall  (in_stall),
    .accept    (accept),
    .rd_col    (rd_col),
    .a_valid   (a_valid),
    .a_pix     (a_pix),
    .a_col     (a_col),
    .a_flags   (a_flags)
  );

  // read the column on acceptance; shift the rows down when stage A advances
  rsc_line_mem #(
    .DEPTH (MAX_WIDTH)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (rd_col),
    .wr_en   (advance),
    .wr_addr (a_col),
    .wr_data ({line_word[PIX_W-1:0], a_pix}),
    .rd_data (line_word)
  );

  rsc_kernel u_kernel (
    .clk    (clk),
    .rst    (rst),
    .load   (advance),
    .upper  (line_word[2*PIX_W-1:PIX_W]),
    .middle (line_word[PIX_W-1:0]),
    .px     (a_pix),
    .flags  (a_flags),
    .cand   (cand)
  );

  rsc_result_q u_result_q (
    .clk          (clk),
    .rst          (rst),
    .load         (advance),
    .cand         (cand),
    .out_stall    (out_stall),
    .free         (res_free),
    .out_valid    (out_valid),
    .out_pix      (out_pix),
    .last_of_run  (last_of_run),
    .end_of_frame (end_of_frame)
  );

  assign red_out   = out_pix[7:0];
  assign green_out = out_pix[15:8];
  assign blue_out  = out_pix[23:16];

endmodule

`default_nettype wire

// File: rtl/rsc_checker.sv
// Port-level checks for the RGB 3x3 sharpen core, bound to its top level.
// Sees only the top-level ports; no package dependency.
`default_nettype none

module rsc_checker (
  input wire       clk,
  input wire       rst,
  input wire       in_stall,
  input wire       out_valid,
  input wire       out_stall,
  input wire [7:0] red_out,
  input wire [7:0] green_out,
  input wire [7:0] blue_out,
  input wire       last_of_run,
  input wire       end_of_frame
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=>
      out_valid && $stable({red_out, green_out, blue_out, last_of_run, end_of_frame}))
    else $error("stalled output transaction changed");

  // the frame's final pixel closes its run
  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_frame |-> last_of_run)
    else $error("end_of_frame without last_of_run");

  // a run of results from one pixel leaves without gaps
  a_run_cont: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_of_run |=> out_valid)
    else $error("gap inside a result run");

  // reset empties both sides of the pipeline
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

bind rgb_sharpen_convolution_3x3_core rsc_checker u_rsc_checker (.*);

`default_nettype wire

// File: sim/tb_rgb_sharpen_convolution_3x3_core.sv
// Self-checking testbench for the RGB 3x3 sharpen convolution core.
// Holds its own line-buffer predictor; depends on rsc_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_rgb_sharpen_convolution_3x3_core;
  import rsc_pkg::*;

  localparam int LINE_DEPTH = 2048;
  localparam int PAUSE_CYCLES = 8;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_run;
    logic       frame_end;
  } out_pix_t;

  // Clock, reset and block ports; every input starts at a known value
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] red_in = '0;
  logic [7:0] green_in = '0;
  logic [7:0] blue_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic last_of_run;
  logic end_of_frame;

  // Pixels waiting to be driven and filtered pixels waiting to come out
  rgb_t     pixel_feed_q [$];
  out_pix_t filtered_q [$];
  int       pixels_queued = 0;
  int       pixels_taken = 0;
  int       mismatches = 0;
  int       sender_idle_pct = 0;
  int       receiver_idle_pct = 0;

  // Predictor state: mirror of the frame registers, line stores and window
  logic [11:0] frame_width_reg = 12'd640;
  logic [12:0] frame_height_reg = 13'd480;
  bit [PIX_W-1:0] upper_line [LINE_DEPTH];
  bit [PIX_W-1:0] middle_line [LINE_DEPTH];
  bit [PIX_W-1:0] win [9];
  int row_cnt = 0;
  int col_cnt = 0;

  rgb_t     drive_pix;
  out_pix_t seen_pix;
  out_pix_t want_pix;

  rgb_sharpen_convolution_3x3_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .red_in       (red_in),
    .green_in     (green_in),
    .blue_in      (blue_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .red_out      (red_out),
    .green_out    (green_out),
    .blue_out     (blue_out),
    .last_of_run  (last_of_run),
    .end_of_frame (end_of_frame)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Effective frame size: the registers are clamped to the supported range
  function automatic int cols_of(input logic [11:0] v);
    return (v < 2) ? 2 : ((v > LINE_DEPTH) ? LINE_DEPTH : int'(v));
  endfunction

  function automatic int rows_of(input logic [12:0] v);
    return (v < 2) ? 2 : ((v > MAX_HEIGHT) ? MAX_HEIGHT : int'(v));
  endfunction

  // Five-point sharpen on the window centre, per channel: absolute value
  // of the sum, wrapped to eight bits with no saturation
  function automatic pix_t sharpen_centre();
    int v;
    int ch;
    pix_t res;
    res = '0;
    for (ch = 0; ch < 3; ch++) begin
      v = 5 * int'(win[4][8*ch +: 8]) - int'(win[1][8*ch +: 8])
        - int'(win[7][8*ch +: 8]) - int'(win[3][8*ch +: 8])
        - int'(win[5][8*ch +: 8]);
      if (v < 0) v = -v;
      res[8*ch +: 8] = v[7:0];
    end
    return res;
  endfunction

  // Advance the predictor by one accepted pixel and queue the filtered
  // pixels it releases, in raster order
  function automatic void convolve_pixel(input rgb_t in_px);
    int w;
    int h;
    int r;
    int c;
    int n;
    int k;
    pix_t px;
    pix_t rel [4];
    logic rel_eof [4];
    w = cols_of(frame_width_reg);
    h = rows_of(frame_height_reg);
    // A counter left beyond a shrunk frame counts as the last row/column
    r = (row_cnt > h - 1) ? h - 1 : row_cnt;
    c = (col_cnt > w - 1) ? w - 1 : col_cnt;
    px = {in_px.blue, in_px.green, in_px.red};
    n = 0;
    for (k = 0; k < 3; k++) begin
      win[k*3]     = win[k*3 + 1];
      win[k*3 + 1] = win[k*3 + 2];
    end
    win[2] = upper_line[c];
    win[5] = middle_line[c];
    win[8] = px;
    upper_line[c]  = middle_line[c];
    middle_line[c] = px;
    if (r >= 1) begin
      if (c >= 1) begin
        // Border pixels of the row above pass through unfiltered
        rel[n] = (r >= 2 && c >= 2) ? sharpen_centre() : win[4];
        rel_eof[n] = 1'b0;
        n++;
      end
      if (c == w - 1) begin
        rel[n] = win[5];
        rel_eof[n] = 1'b0;
        n++;
      end
    end
    if (r == h - 1) begin
      // Bottom row is all border: flush it straight behind the row above
      if (c >= 1) begin
        rel[n] = win[7];
        rel_eof[n] = 1'b0;
        n++;
      end
      if (c == w - 1) begin
        rel[n] = win[8];
        rel_eof[n] = 1'b1;
        n++;
      end
    end
    for (k = 0; k < n; k++)
      filtered_q.push_back('{rel[k][7:0], rel[k][15:8], rel[k][23:16],
                             (k == n - 1), rel_eof[k]});
    if (c == w - 1) begin
      col_cnt = 0;
      row_cnt = (r == h - 1) ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
      row_cnt = r;
    end
  endfunction

  function automatic void note_mismatch(input string what, input out_pix_t got,
                                        input out_pix_t want);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: expected rgb=%0d,%0d,%0d last=%0d eof=%0d, got rgb=%0d,%0d,%0d",
               what, want.red, want.green, want.blue, want.last_run, want.frame_end,
               got.red, got.green, got.blue, " last=%0d eof=%0d",
               got.last_run, got.frame_end);
  endfunction

  // Driver: predict on every accepted transaction, then present the next
  // pending pixel unless this cycle is picked as a sender gap
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        convolve_pixel('{red_in, green_in, blue_in});
        pixels_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (pixel_feed_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          drive_pix = pixel_feed_q.pop_front();
          in_valid <= 1'b1;
          red_in   <= drive_pix.red;
          green_in <= drive_pix.green;
          blue_in  <= drive_pix.blue;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted output transaction against the oldest
  // prediction, and stall the output at random
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        seen_pix = '{red_out, green_out, blue_out, last_of_run, end_of_frame};
        if (filtered_q.size() == 0) begin
          note_mismatch("unexpected output", seen_pix, '0);
        end else begin
          want_pix = filtered_q.pop_front();
          if (seen_pix !== want_pix) note_mismatch("mismatch", seen_pix, want_pix);
        end
      end
      out_stall <= ($urandom_range(99) < receiver_idle_pct);
    end
  end

  function automatic void queue_pixel(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b);
    pixel_feed_q.push_back('{r, g, b});
    pixels_queued++;
  endfunction

  // Channel values lean towards the rails so that wrap and sign both show
  function automatic logic [7:0] rand_level();
    case ($urandom_range(3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic void queue_random(input int count);
    int k;
    for (k = 0; k < count; k++) queue_pixel(rand_level(), rand_level(), rand_level());
  endfunction

  // Write one frame register at a clock edge and mirror it in the predictor
  task automatic write_frame_reg(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_FRAME_WIDTH) frame_width_reg = val[11:0];
    else frame_height_reg = val;
  endtask

  // Hold off until every queued pixel is taken and every prediction has
  // come out, then let the pipeline settle for pixels that release nothing
  task automatic wait_drained();
    while (pixels_taken != pixels_queued || filtered_q.size() != 0) @(posedge clk);
    repeat (PAUSE_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin sender_idle_pct = 8;  receiver_idle_pct = 45; end
      1: begin sender_idle_pct = 45; receiver_idle_pct = 8;  end
      default: begin sender_idle_pct = 0; receiver_idle_pct = 0; end
    endcase
  endtask

  initial begin
    int row;
    int col;
    int w_val;
    int h_val;
    int frames;
    int f;
    int random_items;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    set_idling(0);

    // Checkerboard 5x5: red peaks over zero neighbours (sum wraps past 255),
    // green dips under full neighbours (negative sum), blue ramps to 255
    write_frame_reg(CFG_FRAME_WIDTH, 13'd5);
    write_frame_reg(CFG_FRAME_HEIGHT, 13'd5);
    for (row = 0; row < 5; row++)
      for (col = 0; col < 5; col++)
        queue_pixel(((row + col) % 2 == 0) ? 8'hFF : 8'h00,
                    ((row + col) % 2 == 0) ? 8'h00 : 8'hFF,
                    (row == 4 && col == 4) ? 8'hFF : 8'((row * 5 + col) * 10));
    wait_drained();

    // Sizes below the minimum clamp to 2x2; two frames back to back wrap
    write_frame_reg(CFG_FRAME_WIDTH, 13'd0);
    write_frame_reg(CFG_FRAME_HEIGHT, 13'd1);
    queue_random(8);
    wait_drained();
    write_frame_reg(CFG_FRAME_WIDTH, 13'd1);
    write_frame_reg(CFG_FRAME_HEIGHT, 13'd0);
    queue_random(4);
    wait_drained();

    set_idling(1);
    // Oversized height clamps; shrink it mid-frame so the current row
    // becomes the last one
    write_frame_reg(CFG_FRAME_WIDTH, 13'd6);
    write_frame_reg(CFG_FRAME_HEIGHT, 13'h1FFF);
    queue_random(3 * 6 + 2);
    wait_drained();
    write_frame_reg(CFG_FRAME_HEIGHT, 13'd3);
    queue_random(4);
    wait_drained();

    // Shrink the width mid-row so the column counter lies past the new edge
    write_frame_reg(CFG_FRAME_WIDTH, 13'd8);
    write_frame_reg(CFG_FRAME_HEIGHT, 13'd6);
    queue_random(3 * 8 + 5);
    wait_drained();
    write_frame_reg(CFG_FRAME_WIDTH, 13'd4);
    queue_random(1 + 2 * 4);
    wait_drained();

    set_idling(2);
    // Oversized width clamps to the full line store: start a long row,
    // then narrow the frame so the column counter lies past the new edge
    write_frame_reg(CFG_FRAME_WIDTH, 13'h1FFF);
    write_frame_reg(CFG_FRAME_HEIGHT, 13'd2);
    queue_random(40);
    wait_drained();
    write_frame_reg(CFG_FRAME_WIDTH, 13'd6);
    queue_random(1 + 6);
    wait_drained();

    // Random frames, whole ones only, sized at random, idling mode stepped as the run goes on
    random_items = 0;
    while (random_items < 280) begin
      set_idling(random_items * 3 / 280);
      f = $urandom_range(99);
      w_val = (f < 10) ? $urandom_range(1, 0) :
              (f < 85) ? $urandom_range(10, 2) : $urandom_range(24, 11);
      f = $urandom_range(99);
      h_val = (f < 10) ? $urandom_range(1, 0) : $urandom_range(6, 2);
      write_frame_reg(CFG_FRAME_WIDTH, 13'(w_val));
      write_frame_reg(CFG_FRAME_HEIGHT, 13'(h_val));
      frames = $urandom_range(2, 1);
      for (f = 0; f < frames; f++) begin
        queue_random(cols_of(12'(w_val)) * rows_of(13'(h_val)));
        random_items += cols_of(12'(w_val)) * rows_of(13'(h_val));
      end
      wait_drained();
    end

    // Catch any stray output after the last prediction is consumed
    repeat (16) @(posedge clk);
    if (mismatches == 0 && filtered_q.size() == 0) begin
      $display("rgb_sharpen_convolution_3x3_core test passed");
    end else begin
      $display("rgb_sharpen_convolution_3x3_core test failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #4000000;
    $display("rgb_sharpen_convolution_3x3_core test failed");
    $finish;
  end

endmodule
